/* rtl/sst_pkg.sv */
// Package for the sorted score table: sizes, status codes and the types
// shared by the cell row, the channel interfaces and the top level.
// Depends on nothing.
`default_nettype none

package sst_pkg;

  // Table size and field widths.
  localparam int DEPTH    = 16;
  localparam int KEY_W    = 64;
  localparam int KIND_W   = 2;
  localparam int SCORE_W  = 16;
  localparam int RANK_W   = 4;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 5;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int RANK_LIM = 2 ** RANK_W;

  // Item modes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_RAISED    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DROPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ_OK   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_READ_EMPT = 3'd5;

  // One stored entry.
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [KIND_W-1:0]         kind;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic cmp_en;
    logic wr_en;
    logic raise;
  } cell_ctrl_t;

  // Flags one cell hands to the next one down the row.
  typedef struct packed {
    logic ahead;
    logic match;
    logic past;
  } cell_flags_t;

endpackage

`default_nettype wire

/* rtl/sst_in_if.sv */
// Input channel of the sorted score table: valid, ready and one request word.
// Depends on sst_pkg.
`default_nettype none

interface sst_in_if import sst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [KEY_W-1:0]          owner_key;
  logic [KIND_W-1:0]         entry_kind;
  logic signed [SCORE_W-1:0] new_score;
  logic [RANK_W-1:0]         read_rank;

  modport source (output valid, mode, owner_key, entry_kind, new_score, read_rank,
                  input ready);
  modport sink   (input valid, mode, owner_key, entry_kind, new_score, read_rank,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sst_out_if.sv */
// Result channel of the sorted score table: valid, ready and one result word.
// Depends on sst_pkg.
`default_nettype none

interface sst_out_if import sst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [RANK_W-1:0]         rank;
  logic [KEY_W-1:0]          out_key;
  logic [KIND_W-1:0]         out_kind;
  logic signed [SCORE_W-1:0] out_score;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, status, rank, out_key, out_kind, out_score, fill_count,
                  input ready);
  modport sink   (input valid, status, rank, out_key, out_kind, out_score, fill_count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sst_cell.sv */
// One slot of the sorted score table: holds an entry, compares it with the
// offered word and shifts from its upper neighbour on an insert.
// Depends on sst_pkg.
`default_nettype none

module sst_cell import sst_pkg::*; (
  input  wire logic                      clk,
  input  wire cell_ctrl_t                ctrl,
  input  wire logic [KEY_W-1:0]          cmp_key,
  input  wire logic [KIND_W-1:0]         cmp_kind,
  input  wire logic signed [SCORE_W-1:0] cmp_score,
  input  wire entry_t                    new_ent,
  input  wire logic                      slot_valid,
  input  wire logic                      pick,
  input  wire entry_t                    left_ent,
  input  wire cell_flags_t               left_flags,
  output entry_t                         ent,
  output cell_flags_t                    flags,
  output entry_t                         pick_ent
);

  entry_t ent_r, ent_nxt;
  logic   ahead_r, ahead_nxt;
  logic   match_r, match_nxt;
  logic   keep;

  // Compare against the offered word when it is accepted. An entry is ahead
  // when it is valid and its score is not below the offered one.
  always_comb begin
    ahead_nxt = ahead_r;
    match_nxt = match_r;
    if (ctrl.cmp_en) begin
      ahead_nxt = slot_valid && !(ent_r.score < cmp_score);
      match_nxt = slot_valid && (ent_r.key == cmp_key) && (ent_r.kind == cmp_kind);
    end
  end

  // Entries ahead of the insertion point stay, as do those below a raised
  // entry. The first cell that is not ahead takes the new entry; the cells
  // below it take their upper neighbour's entry.
  always_comb begin
    keep    = ahead_r || (ctrl.raise && left_flags.past);
    ent_nxt = ent_r;
    if (ctrl.wr_en && !keep) begin
      if (left_flags.ahead) begin
        ent_nxt = new_ent;
      end else begin
        ent_nxt = left_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    ahead_r <= ahead_nxt;
    match_r <= match_nxt;
  end

  // Outputs towards the next cell and the read-out OR tree.
  assign ent         = ent_r;
  assign flags.ahead = ahead_r;
  assign flags.match = match_r;
  assign flags.past  = left_flags.past || match_r;
  assign pick_ent    = pick ? ent_r : entry_t'('0);

endmodule

`default_nettype wire

/* rtl/sorted_score_table.sv */
// Top level of the sorted score table: a row of sst_cell slots, the fill
// count, the request register and the result register.
// Depends on sst_pkg, sst_in_if, sst_out_if and sst_cell.
//
//   Channel   Dir  Handshake        Word
//   in_ch     in   valid / ready    mode, owner_key, entry_kind, new_score, read_rank
//   out_ch    out  valid / ready    status, rank, out_key, out_kind, out_score, fill_count
//
// An item is handled as follows: at acceptance every cell compares its entry
// with the offered word, and in the update step the row shifts on an insert
// and the result word is loaded. The next word is taken only after the update step.
// A result waiting on out_ch holds back only the update step, not acceptance.
// Reset clears the state, the fill count and the result valid flag; slot contents are undefined until written.
`default_nettype none

module sorted_score_table import sst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sst_in_if.sink     in_ch,
  sst_out_if.source  out_ch
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Request register.
  logic              req_mode_r;
  entry_t            req_ent_r;
  logic [RANK_W-1:0] req_rd_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [RANK_W-1:0]   out_rank_r, out_rank_nxt;
  entry_t              out_ent_r, out_ent_nxt;
  logic [FILL_W-1:0]   out_fill_r, out_fill_nxt;

  // Cell row.
  cell_ctrl_t        ctrl;
  entry_t            cell_ent [DEPTH];
  cell_flags_t       cell_flg [DEPTH];
  entry_t            pick_ent [DEPTH];
  logic [DEPTH-1:0]  slot_valid, pick, rd_sel;
  logic [DEPTH-1:0]  match_vec, ahead_vec, left_ahead_vec, pos_vec;

  logic              accept, commit;
  logic              found, not_higher, all_ahead, rd_hit;
  logic [RANK_W-1:0] pos_rank, found_rank;
  entry_t            picked;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign commit      = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);

  // Slot occupancy and read selection follow from the fill count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_valid[i] = CNT_W'(i) < count_r;
      rd_sel[i]     = slot_valid[i] && (RANK_W'(i) == req_rd_r) && (i < RANK_LIM);
      match_vec[i]  = cell_flg[i].match;
      ahead_vec[i]  = cell_flg[i].ahead;
    end
  end

  assign pick = (req_mode_r == MODE_READ) ? rd_sel : match_vec;

  // Row of cells; the top cell sees an upper neighbour that is always ahead.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t      left_ent;
    cell_flags_t left_flags;
    if (g == 0) begin : g_top
      assign left_ent   = req_ent_r;
      assign left_flags = cell_flags_t'{ahead: 1'b1, match: 1'b0, past: 1'b0};
    end else begin : g_rest
      assign left_ent   = cell_ent[g-1];
      assign left_flags = cell_flg[g-1];
    end
    sst_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cmp_key    (in_ch.owner_key),
      .cmp_kind   (in_ch.entry_kind),
      .cmp_score  (in_ch.new_score),
      .new_ent    (req_ent_r),
      .slot_valid (slot_valid[g]),
      .pick       (pick[g]),
      .left_ent   (left_ent),
      .left_flags (left_flags),
      .ent        (cell_ent[g]),
      .flags      (cell_flg[g]),
      .pick_ent   (pick_ent[g])
    );
  end

  // Insertion point, found slot and the selected entry.
  always_comb begin
    left_ahead_vec = {ahead_vec[DEPTH-2:0], 1'b1};
    pos_vec        = ~ahead_vec & left_ahead_vec;
    found          = |match_vec;
    not_higher     = |(match_vec & ahead_vec);
    all_ahead      = &ahead_vec;
    pos_rank       = '0;
    found_rank     = '0;
    picked         = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_rank   = pos_rank | (pos_vec[i] ? RANK_W'(i) : RANK_W'(0));
      found_rank = found_rank | (match_vec[i] ? RANK_W'(i) : RANK_W'(0));
      picked     = entry_t'(picked | pick_ent[i]);
    end
    rd_hit = (CNT_W + RANK_W)'(req_rd_r) < (CNT_W + RANK_W)'(count_r);
  end

  // Broadcast control to the row.
  always_comb begin
    ctrl.cmp_en = accept;
    ctrl.raise  = found;
    ctrl.wr_en  = commit && (req_mode_r == MODE_INSERT) &&
                  !(found && not_higher) && !(!found && all_ahead);
  end

  // Fill count and result word.
  always_comb begin
    count_nxt      = count_r;
    out_status_nxt = out_status_r;
    out_rank_nxt   = out_rank_r;
    out_ent_nxt    = out_ent_r;
    if (commit) begin
      if (req_mode_r == MODE_READ) begin
        out_status_nxt = rd_hit ? STAT_READ_OK : STAT_READ_EMPT;
        out_rank_nxt   = req_rd_r;
        out_ent_nxt    = picked;
      end else if (found && not_higher) begin
        out_status_nxt = STAT_IGNORED;
        out_rank_nxt   = found_rank;
        out_ent_nxt    = picked;
      end else if (found) begin
        out_status_nxt = STAT_RAISED;
        out_rank_nxt   = pos_rank;
        out_ent_nxt    = req_ent_r;
      end else if (all_ahead) begin
        out_status_nxt = STAT_DROPPED;
        out_rank_nxt   = '0;
        out_ent_nxt    = req_ent_r;
      end else begin
        out_status_nxt = STAT_INSERTED;
        out_rank_nxt   = pos_rank;
        out_ent_nxt    = req_ent_r;
        if (count_r < CNT_W'(DEPTH)) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
    out_fill_nxt = FILL_W'(count_nxt);
  end

  // Handshake state.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request word is captured on acceptance; result word on commit.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r      <= in_ch.mode;
      req_ent_r.key   <= in_ch.owner_key;
      req_ent_r.kind  <= in_ch.entry_kind;
      req_ent_r.score <= in_ch.new_score;
      req_rd_r        <= in_ch.read_rank;
    end
    out_status_r <= out_status_nxt;
    out_rank_r   <= out_rank_nxt;
    out_ent_r    <= out_ent_nxt;
    if (commit) begin
      out_fill_r <= out_fill_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.rank       = out_rank_r;
  assign out_ch.out_key    = out_ent_r.key;
  assign out_ch.out_kind   = out_ent_r.kind;
  assign out_ch.out_score  = out_ent_r.score;
  assign out_ch.fill_count = out_fill_r;

`ifndef SYNTHESIS
  // Key and kind pairs are unique in the table, so at most one slot can match.
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(match_vec))
    else $error("more than one slot matches the offered key");

  // There is at most one insertion point.
  a_pos_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(pos_vec))
    else $error("more than one insertion point");

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond table size");

  // A result appears only in the cycle after an update step.
  a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result word without an update step");

  // The fill count changes only through an update step.
  a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(count_r))
    else $error("fill count changed while idle");
`endif

endmodule

`default_nettype wire
